// ----- rtl/core/slab_object_allocator_assert.svh -----
// Assertion macros shared by the slab object allocator RTL.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab allocator check failed");

`endif

// ----- rtl/core/soa_pkg.sv -----
// Shared types, codes and helpers for the slab object allocator.
package soa_pkg;

    localparam int DEF_NUM_SLABS        = 16;
    localparam int DEF_OBJECTS_PER_SLAB = 5;

    // Index width for a range of n values, never below one bit.
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    typedef enum logic [1:0] {
        CLS_UNUSED  = 2'd0,
        CLS_EMPTY   = 2'd1,
        CLS_PARTIAL = 2'd2,
        CLS_FULL    = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SLAB     = 2'd1,
        ST_NOT_FOUND   = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_MOD
    } t_state;

    // Class/recency update request toward the order tracker
    typedef struct packed {
        logic   wr;
        logic   front;
        t_class cls;
    } t_order_upd;

    // Search and probe results from the order tracker
    typedef struct packed {
        logic   part_found;
        logic   empty_found;
        t_class probe_cls;
    } t_search;

endpackage

// ----- rtl/core/soa_slab_mem.sv -----
// Slab record memory: used bitmap and use count, registered read.
module soa_slab_mem import soa_pkg::*; #(
    parameter int NUM_SLABS        = DEF_NUM_SLABS,
    parameter int OBJECTS_PER_SLAB = DEF_OBJECTS_PER_SLAB
) (
    input  logic                                  i_clk,
    input  logic                                  i_rd_en,
    input  logic [idx_w(NUM_SLABS)-1:0]           i_rd_addr,
    output logic [OBJECTS_PER_SLAB-1:0]           o_rd_bits,
    output logic [$clog2(OBJECTS_PER_SLAB+1)-1:0] o_rd_count,
    input  logic                                  i_wr_en,
    input  logic [idx_w(NUM_SLABS)-1:0]           i_wr_addr,
    input  logic [OBJECTS_PER_SLAB-1:0]           i_wr_bits,
    input  logic [$clog2(OBJECTS_PER_SLAB+1)-1:0] i_wr_count
);

    localparam int CNT_W = $clog2(OBJECTS_PER_SLAB + 1);
    localparam int REC_W = OBJECTS_PER_SLAB + CNT_W;

    logic [REC_W-1:0] r_mem [NUM_SLABS];
    logic [REC_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_bits, i_wr_count};
        end
    end

    // Registered read port, holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bits  = r_rd_data[REC_W-1:CNT_W];
    assign o_rd_count = r_rd_data[CNT_W-1:0];

endmodule

// ----- rtl/core/soa_order.sv -----
// Slab classes and shared move-to-front recency order, with class search.
module soa_order import soa_pkg::*; #(
    parameter int NUM_SLABS = DEF_NUM_SLABS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_order_upd                  i_upd,
    input  logic [idx_w(NUM_SLABS)-1:0] i_upd_slab,
    input  logic [idx_w(NUM_SLABS)-1:0] i_probe_slab,
    output t_search                     o_search,
    output logic [idx_w(NUM_SLABS)-1:0] o_part_slab,
    output logic [idx_w(NUM_SLABS)-1:0] o_empty_slab
);

`include "slab_object_allocator_assert.svh"

    localparam int SLAB_W = idx_w(NUM_SLABS);

    t_class              r_class [NUM_SLABS];
    logic [SLAB_W-1:0]   r_rank  [NUM_SLABS];

    logic [SLAB_W-1:0]   front_rank;
    logic [NUM_SLABS-1:0] match     [2];
    logic [NUM_SLABS-1:0] rank_hit  [2];
    logic [NUM_SLABS-1:0] below     [2];
    logic [NUM_SLABS-1:0] best_oh   [2];
    logic [SLAB_W-1:0]    best_idx  [2];
    logic [NUM_SLABS-1:0] rank_seen;

    assign front_rank = r_rank[i_upd_slab];

    // Class write and move-to-front of the updated slab
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLABS; i++) begin
                r_class[i] <= CLS_UNUSED;
                r_rank[i]  <= SLAB_W'(i);
            end
        end else if (i_upd.wr) begin
            for (int i = 0; i < NUM_SLABS; i++) begin
                if (i_upd_slab == SLAB_W'(i)) begin
                    r_class[i] <= i_upd.cls;
                    if (i_upd.front) begin
                        r_rank[i] <= '0;
                    end
                end else if (i_upd.front && (r_rank[i] < front_rank)) begin
                    r_rank[i] <= r_rank[i] + SLAB_W'(1);
                end
            end
        end
    end

    // Most recent slab of a class: map matches onto rank positions, then
    // pick the slab whose rank has no matching rank below it.
    // Lane 0 searches partial slabs, lane 1 empty slabs.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            match[k]    = '0;
            rank_hit[k] = '0;
            best_oh[k]  = '0;
            best_idx[k] = '0;
            for (int i = 0; i < NUM_SLABS; i++) begin
                match[k][i] = (r_class[i] == ((k == 0) ? CLS_PARTIAL : CLS_EMPTY));
                if (match[k][i]) begin
                    rank_hit[k][r_rank[i]] = 1'b1;
                end
            end
            for (int r = 0; r < NUM_SLABS; r++) begin
                below[k][r] = |(rank_hit[k] & ~({NUM_SLABS{1'b1}} << r));
            end
            for (int i = 0; i < NUM_SLABS; i++) begin
                best_oh[k][i] = match[k][i] && !below[k][r_rank[i]];
                if (best_oh[k][i]) begin
                    best_idx[k] = best_idx[k] | SLAB_W'(i);
                end
            end
        end
    end

    assign o_search.part_found  = |match[0];
    assign o_search.empty_found = |match[1];
    assign o_search.probe_cls   = r_class[i_probe_slab];
    assign o_part_slab          = best_idx[0];
    assign o_empty_slab         = best_idx[1];

    // Rank occupancy, checked to stay a permutation
    always_comb begin
        rank_seen = '0;
        for (int i = 0; i < NUM_SLABS; i++) begin
            rank_seen[r_rank[i]] = 1'b1;
        end
    end

    `SOA_ASSERT_IMPL(a_rank_perm, i_clk, i_rst_n, 1'b1, &rank_seen)
    `SOA_ASSERT_IMPL(a_part_pick, i_clk, i_rst_n, 1'b1, $onehot0(best_oh[0]))
    `SOA_ASSERT_IMPL(a_empty_pick, i_clk, i_rst_n, 1'b1, $onehot0(best_oh[1]))
    `SOA_ASSERT_NEXT(a_front_zero, i_clk, i_rst_n, i_upd.wr && i_upd.front,
        r_rank[$past(i_upd_slab)] == '0)

endmodule

// ----- rtl/core/slab_object_allocator.sv -----
// Slab object allocator top level: request sequencer around the slab record memory.
// A result is registered after the search state (S_FIND) and then the read-modify-write state (S_MOD).
// A new request is taken only while the sequencer is idle, so one transaction is in flight at a
// time; a stalled output holds the sequencer in its write-back state (S_MOD).
// Reset (synchronous, active low) marks every slab unused, sets rank to slab index and
// clears the fresh-slab counter; the record memory is not swept, unused slabs read as zero.
module slab_object_allocator import soa_pkg::*; #(
    parameter int NUM_SLABS        = DEF_NUM_SLABS,
    parameter int OBJECTS_PER_SLAB = DEF_OBJECTS_PER_SLAB
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_command,
    input  logic [idx_w(NUM_SLABS)-1:0]        i_slab_index,
    input  logic [idx_w(OBJECTS_PER_SLAB)-1:0] i_object_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic [idx_w(NUM_SLABS)-1:0]        o_granted_slab,
    output logic [idx_w(OBJECTS_PER_SLAB)-1:0] o_granted_object
);

`include "slab_object_allocator_assert.svh"

    localparam int SLAB_W = idx_w(NUM_SLABS);
    localparam int OBJ_W  = idx_w(OBJECTS_PER_SLAB);
    localparam int CNT_W  = $clog2(OBJECTS_PER_SLAB + 1);
    localparam int NU_W   = $clog2(NUM_SLABS + 1);

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [SLAB_W-1:0]     r_sidx;
    logic [OBJ_W-1:0]      r_oidx;
    logic [SLAB_W-1:0]     r_slab, n_slab;
    t_class                r_src, n_src;
    logic                  r_hit, n_hit;
    logic [NU_W-1:0]       r_next_unused, n_next_unused;
    logic                  r_out_valid;
    t_status               r_status, n_status;
    logic [SLAB_W-1:0]     r_gslab, n_gslab;
    logic [OBJ_W-1:0]      r_gobj, n_gobj;

    logic                  accept;
    logic                  ld_out;
    logic                  sidx_ok, oidx_ok;
    t_order_upd            upd;
    t_search               srch;
    logic [SLAB_W-1:0]     part_slab, empty_slab;
    logic                  rd_en, wr_en;
    logic [OBJECTS_PER_SLAB-1:0] rd_bits, cur_bits, wr_bits, free_mask, low_oh;
    logic [CNT_W-1:0]      rd_cnt, cur_cnt, wr_cnt;
    logic [OBJ_W-1:0]      low_idx;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    assign sidx_ok = ({1'b0, r_sidx} < (SLAB_W + 1)'(NUM_SLABS));
    assign oidx_ok = ({1'b0, r_oidx} < (OBJ_W + 1)'(OBJECTS_PER_SLAB));

    // A never-used slab has no written record: treat it as all clear
    assign cur_bits = (r_src == CLS_UNUSED) ? '0 : rd_bits;
    assign cur_cnt  = (r_src == CLS_UNUSED) ? '0 : rd_cnt;

    // Lowest free object of the slab
    assign free_mask = ~cur_bits;
    assign low_oh    = free_mask & (~free_mask + OBJECTS_PER_SLAB'(1));
    always_comb begin
        low_idx = '0;
        for (int j = 0; j < OBJECTS_PER_SLAB; j++) begin
            if (low_oh[j]) begin
                low_idx = low_idx | OBJ_W'(j);
            end
        end
    end

    assign rd_en = (r_state == S_FIND);

    // Sequencer: next state, slab choice and write-back
    always_comb begin
        n_state       = r_state;
        n_slab        = r_slab;
        n_src         = r_src;
        n_hit         = r_hit;
        n_next_unused = r_next_unused;
        n_status      = ST_OK;
        n_gslab       = '0;
        n_gobj        = '0;
        ld_out        = 1'b0;
        wr_en         = 1'b0;
        wr_bits       = cur_bits;
        wr_cnt        = cur_cnt;
        upd.wr        = 1'b0;
        upd.front     = 1'b0;
        upd.cls       = CLS_UNUSED;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_MOD;
                if (r_cmd == CMD_ALLOC) begin
                    if (srch.part_found) begin
                        n_slab = part_slab;
                        n_src  = CLS_PARTIAL;
                        n_hit  = 1'b1;
                    end else if (srch.empty_found) begin
                        n_slab = empty_slab;
                        n_src  = CLS_EMPTY;
                        n_hit  = 1'b1;
                    end else if (r_next_unused < NU_W'(NUM_SLABS)) begin
                        n_slab = r_next_unused[SLAB_W-1:0];
                        n_src  = CLS_UNUSED;
                        n_hit  = 1'b1;
                    end else begin
                        n_slab = '0;
                        n_src  = CLS_UNUSED;
                        n_hit  = 1'b0;
                    end
                end else begin
                    n_slab = r_sidx;
                    n_src  = srch.probe_cls;
                    n_hit  = sidx_ok && oidx_ok &&
                             (srch.probe_cls == CLS_PARTIAL || srch.probe_cls == CLS_FULL);
                end
            end
            S_MOD: begin
                if (!r_out_valid || !i_stall) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_ALLOC) begin
                        if (!r_hit) begin
                            n_status = ST_NO_SLAB;
                        end else begin
                            wr_en     = 1'b1;
                            wr_bits   = cur_bits | low_oh;
                            wr_cnt    = cur_cnt + CNT_W'(1);
                            upd.wr    = 1'b1;
                            upd.cls   = (wr_cnt == CNT_W'(OBJECTS_PER_SLAB)) ?
                                        CLS_FULL : CLS_PARTIAL;
                            upd.front = (r_src != CLS_PARTIAL) || (upd.cls == CLS_FULL);
                            n_gslab   = r_slab;
                            n_gobj    = low_idx;
                            if (r_src == CLS_UNUSED) begin
                                n_next_unused = r_next_unused + NU_W'(1);
                            end
                        end
                    end else if (!r_hit) begin
                        n_status = ST_NOT_FOUND;
                    end else if (!cur_bits[r_oidx]) begin
                        n_status = ST_DOUBLE_FREE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_bits   = cur_bits & ~(OBJECTS_PER_SLAB'(1) << r_oidx);
                        wr_cnt    = cur_cnt - CNT_W'(1);
                        upd.wr    = 1'b1;
                        upd.front = 1'b1;
                        upd.cls   = (wr_cnt == '0) ? CLS_EMPTY : CLS_PARTIAL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_next_unused <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_next_unused <= n_next_unused;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_sidx <= i_slab_index;
            r_oidx <= i_object_index;
        end
        r_slab <= n_slab;
        r_src  <= n_src;
        r_hit  <= n_hit;
        if (ld_out) begin
            r_status <= n_status;
            r_gslab  <= n_gslab;
            r_gobj   <= n_gobj;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_slab   = r_gslab;
    assign o_granted_object = r_gobj;

    soa_order #(
        .NUM_SLABS (NUM_SLABS)
    ) u_order (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (upd),
        .i_upd_slab   (r_slab),
        .i_probe_slab (r_sidx),
        .o_search     (srch),
        .o_part_slab  (part_slab),
        .o_empty_slab (empty_slab)
    );

    soa_slab_mem #(
        .NUM_SLABS        (NUM_SLABS),
        .OBJECTS_PER_SLAB (OBJECTS_PER_SLAB)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (n_slab),
        .o_rd_bits  (rd_bits),
        .o_rd_count (rd_cnt),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_slab),
        .i_wr_bits  (wr_bits),
        .i_wr_count (wr_cnt)
    );

    `SOA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_stall)
    `SOA_ASSERT_IMPL(a_unused_bound, i_clk, i_rst_n, 1'b1,
        r_next_unused <= NU_W'(NUM_SLABS))
    `SOA_ASSERT_NEXT(a_grant_range, i_clk, i_rst_n,
        ld_out && (r_cmd == CMD_ALLOC) && (n_status == ST_OK),
        o_valid && ({1'b0, o_granted_object} < (OBJ_W + 1)'(OBJECTS_PER_SLAB)))
    `SOA_ASSERT_IMPL(a_write_only_mod, i_clk, i_rst_n, wr_en || upd.wr,
        (r_state == S_MOD) && r_hit && ld_out)

endmodule

// ----- tb/tb_slab_object_allocator.sv -----
// Self-checking testbench for the slab object allocator: directed and random requests.
module tb_slab_object_allocator import soa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLABS      = DEF_NUM_SLABS;
    localparam int OBJS       = DEF_OBJECTS_PER_SLAB;
    localparam int SW         = idx_w(SLABS);
    localparam int OW         = idx_w(OBJS);
    localparam int RAND_ITEMS = 1900;
    localparam int IDLE_LIMIT = 3000;

    // One expected allocator response
    typedef struct {
        t_status        status;
        logic [SW-1:0]  slab;
        logic [OW-1:0]  obj;
    } t_alloc_result;

    // Tracks pool state and the responses still owed by the block
    class t_alloc_scoreboard;
        logic [OBJS-1:0] used_map [SLABS];
        int              live_cnt [SLABS];
        t_class          slab_cls [SLABS];
        int              rank_of  [SLABS];
        int              fresh_next;
        t_alloc_result   owed_q [$];
        int              errors;
        int              status_seen [4];

        function new();
            for (int s = 0; s < SLABS; s++) begin
                used_map[s] = '0;
                live_cnt[s] = 0;
                slab_cls[s] = CLS_UNUSED;
                rank_of[s]  = s;
            end
            fresh_next = 0;
            errors     = 0;
            for (int k = 0; k < 4; k++) status_seen[k] = 0;
        endfunction

        // Move-to-front in the shared recency order
        function void move_to_front(int s);
            int old_rank;
            old_rank = rank_of[s];
            for (int i = 0; i < SLABS; i++)
                if (rank_of[i] < old_rank) rank_of[i]++;
            rank_of[s] = 0;
        endfunction

        // Most recent slab of a class, SLABS if none
        function int most_recent(t_class c);
            int best;
            best = SLABS;
            for (int i = 0; i < SLABS; i++)
                if (slab_cls[i] == c && (best == SLABS || rank_of[i] < rank_of[best]))
                    best = i;
            return best;
        endfunction

        // Accepted request: update pool state and queue the response it owes
        function void note_request(t_cmd cmd, logic [SW-1:0] slab, logic [OW-1:0] obj);
            t_alloc_result r;
            int            s;
            r.status = ST_OK;
            r.slab   = '0;
            r.obj    = '0;
            if (cmd == CMD_ALLOC) begin
                s = most_recent(CLS_PARTIAL);
                if (s == SLABS) begin
                    s = most_recent(CLS_EMPTY);
                    if (s == SLABS && fresh_next < SLABS) begin
                        s = fresh_next;
                        fresh_next++;
                    end
                    if (s != SLABS) begin
                        slab_cls[s] = CLS_PARTIAL;
                        move_to_front(s);
                    end
                end
                if (s == SLABS) begin
                    r.status = ST_NO_SLAB;
                end else begin
                    for (int j = 0; j < OBJS; j++) begin
                        if (!used_map[s][j]) begin
                            used_map[s][j] = 1'b1;
                            live_cnt[s]++;
                            r.slab = SW'(s);
                            r.obj  = OW'(j);
                            break;
                        end
                    end
                    if (live_cnt[s] >= OBJS) begin
                        slab_cls[s] = CLS_FULL;
                        move_to_front(s);
                    end
                end
            end else begin
                if (int'(slab) >= SLABS || int'(obj) >= OBJS ||
                    (slab_cls[slab] != CLS_PARTIAL && slab_cls[slab] != CLS_FULL)) begin
                    r.status = ST_NOT_FOUND;
                end else if (!used_map[slab][obj]) begin
                    r.status = ST_DOUBLE_FREE;
                end else begin
                    used_map[slab][obj] = 1'b0;
                    if (live_cnt[slab] > 0) live_cnt[slab]--;
                    slab_cls[slab] = (live_cnt[slab] == 0) ? CLS_EMPTY : CLS_PARTIAL;
                    move_to_front(int'(slab));
                end
            end
            owed_q.push_back(r);
        endfunction

        // Accepted response: compare against the oldest owed one
        function void check_result(logic [1:0] st, logic [SW-1:0] gs, logic [OW-1:0] go);
            t_alloc_result r;
            if (owed_q.size() == 0) begin
                $error("response with none outstanding: status %0d slab %0d object %0d",
                       st, gs, go);
                errors++;
                return;
            end
            r = owed_q.pop_front();
            status_seen[r.status]++;
            if (st !== r.status) begin
                $error("status mismatch: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (gs !== r.slab) begin
                $error("granted_slab mismatch: expected %0d, actual %0d", r.slab, gs);
                errors++;
            end
            if (go !== r.obj) begin
                $error("granted_object mismatch: expected %0d, actual %0d", r.obj, go);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Random object currently held by a partial or full slab
        function bit pick_live(output logic [SW-1:0] slab, output logic [OW-1:0] obj);
            int cand_s [$];
            int cand_o [$];
            int k;
            for (int s = 0; s < SLABS; s++)
                for (int j = 0; j < OBJS; j++)
                    if (used_map[s][j]) begin
                        cand_s.push_back(s);
                        cand_o.push_back(j);
                    end
            slab = '0;
            obj  = '0;
            if (cand_s.size() == 0) return 1'b0;
            k    = $urandom_range(0, cand_s.size() - 1);
            slab = SW'(cand_s[k]);
            obj  = OW'(cand_o[k]);
            return 1'b1;
        endfunction
    endclass

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_valid        = 1'b0;
    logic          i_command      = 1'b0;
    logic [SW-1:0] i_slab_index   = '0;
    logic [OW-1:0] i_object_index = '0;
    logic          i_stall        = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [SW-1:0] o_granted_slab;
    logic [OW-1:0] o_granted_object;

    t_alloc_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              idle_cycles = 0;
    int              sent = 0;

    slab_object_allocator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_slab_index     (i_slab_index),
        .i_object_index   (i_object_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_granted_slab   (o_granted_slab),
        .o_granted_object (o_granted_object)
    );

    always #10 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and hold it until the transaction is taken
    task automatic send_request(input t_cmd cmd, input logic [SW-1:0] slab,
                                input logic [OW-1:0] obj);
        int gap;
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_slab_index   <= slab;
        i_object_index <= obj;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(cmd, slab, obj);
        sent++;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random request; frees mostly target live objects
    task automatic send_random(input int alloc_pct);
        logic [SW-1:0] s;
        logic [OW-1:0] o;
        if ($urandom_range(0, 99) < alloc_pct) begin
            send_request(CMD_ALLOC, SW'($urandom), OW'($urandom));
        end else if ($urandom_range(0, 99) < 75 && sb.pick_live(s, o)) begin
            send_request(CMD_FREE, s, o);
        end else begin
            send_request(CMD_FREE, SW'($urandom), OW'($urandom));
        end
    endtask

    // Output-side stall pattern
    initial begin : stall_gen
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end else begin
                i_stall <= 1'b1;
                hold = gap_len();
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_granted_slab, o_granted_object);
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main_seq
        int phase_left;
        int alloc_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unused slab, fill and refill, bad object index, double free, empty slab
        send_request(CMD_FREE,  4'd0,  3'd0);
        repeat (6) send_request(CMD_ALLOC, 4'd15, 3'd7);
        send_request(CMD_FREE,  4'd0,  3'd7);
        send_request(CMD_FREE,  4'd0,  3'd5);
        send_request(CMD_FREE,  4'd1,  3'd1);
        send_request(CMD_FREE,  4'd0,  3'd2);
        send_request(CMD_ALLOC, 4'd0,  3'd0);
        send_request(CMD_FREE,  4'd1,  3'd0);
        send_request(CMD_FREE,  4'd1,  3'd0);
        send_request(CMD_ALLOC, 4'd0,  3'd0);
        send_request(CMD_FREE,  4'd15, 3'd4);
        send_request(CMD_FREE,  4'd0,  3'd4);
        send_request(CMD_FREE,  4'd0,  3'd0);
        send_request(CMD_ALLOC, 4'd7,  3'd3);
        send_request(CMD_ALLOC, 4'd8,  3'd6);
        send_request(CMD_FREE,  4'd0,  3'd6);
        send_request(CMD_FREE,  4'd2,  3'd0);

        // Random phases: allocation-heavy ones exhaust the pool, free-heavy ones drain it
        phase_left = 0;
        alloc_pct  = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(60, 200);
                case ($urandom_range(0, 2))
                    0: alloc_pct = 85;
                    1: alloc_pct = 30;
                    default: alloc_pct = 55;
                endcase
                quiet = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            if (n == RAND_ITEMS / 2) begin
                // hold off until the block has answered everything
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            send_random(alloc_pct);
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        // Drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d responses never arrived", sb.pending());
            sb.errors++;
        end

        $display("Ran %0d requests: %0d ok, %0d out of slabs, %0d not found, %0d double free.",
                 sent, sb.status_seen[ST_OK], sb.status_seen[ST_NO_SLAB],
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_DOUBLE_FREE]);
        $display("Pool was filled and drained in phases under random input gaps and stalls.");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- slab_object_allocator.f -----
+incdir+rtl/core
rtl/core/soa_pkg.sv
rtl/core/soa_slab_mem.sv
rtl/core/soa_order.sv
rtl/core/slab_object_allocator.sv
tb/tb_slab_object_allocator.sv
